@@ rtl/assert_macros.svh @@
// Assertion helpers used by the top-level RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk_sig, rstn_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication with the consequent checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk_sig, rstn_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/ppjj_pkg.sv @@
`timescale 1ns / 1ps
package ppjj_pkg;

    localparam int unsigned MAX_STAGES = 32;
    localparam int unsigned ANG_W = 36;
    localparam int unsigned CS_W = 34;

    localparam logic signed [ANG_W-1:0] Q30_PI = 36'sd3373259426;
    localparam logic signed [ANG_W-1:0] Q30_TWO_PI = 36'sd6746518852;
    localparam logic signed [ANG_W-1:0] Q30_HALF_PI = 36'sd1686629713;
    localparam logic signed [CS_W-1:0] Q30_GAIN = 34'sd652032874;

    typedef enum logic [1:0] {
        REG_FIRST_ANCHOR_X = 2'd0,
        REG_FIRST_ANCHOR_Y = 2'd1,
        REG_SECOND_ANCHOR_X = 2'd2,
        REG_SECOND_ANCHOR_Y = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic signed [31:0] first_angle;
        logic signed [31:0] second_angle;
        logic signed [31:0] first_spin_rate;
        logic signed [31:0] second_spin_rate;
        logic signed [31:0] first_pos_x;
        logic signed [31:0] first_pos_y;
        logic signed [31:0] second_pos_x;
        logic signed [31:0] second_pos_y;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] error_x;
        logic signed [31:0] error_y;
        logic signed [31:0] jac_first_row0;
        logic signed [31:0] jac_first_row1;
        logic signed [31:0] jac_second_row0;
        logic signed [31:0] jac_second_row1;
        logic signed [31:0] jdot_first_row0;
        logic signed [31:0] jdot_first_row1;
        logic signed [31:0] jdot_second_row0;
        logic signed [31:0] jdot_second_row1;
    } out_item_t;

    // one CORDIC lane as handed from cell to cell
    typedef struct packed {
        logic signed [CS_W-1:0]  x;
        logic signed [CS_W-1:0]  y;
        logic signed [ANG_W-1:0] z;
        logic                    flip;
    } rot_lane_t;

    function automatic logic signed [ANG_W-1:0] atan_q30(input int unsigned i);
        logic signed [ANG_W-1:0] r;
        case (i)
            0: r = 36'sh03243F6A8;
            1: r = 36'sh01DAC6705;
            2: r = 36'sh00FADBAFC;
            3: r = 36'sh007F56EA6;
            4: r = 36'sh003FEAB76;
            5: r = 36'sh001FFD55B;
            6: r = 36'sh000FFFAAA;
            7: r = 36'sh0007FFF55;
            8: r = 36'sh0003FFFEA;
            9: r = 36'sh0001FFFFD;
            10: r = 36'sh0000FFFFF;
            11: r = 36'sh00007FFFF;
            12: r = 36'sh00003FFFF;
            13: r = 36'sh00001FFFF;
            14: r = 36'sh00000FFFF;
            15: r = 36'sh000007FFF;
            16: r = 36'sh000003FFF;
            17: r = 36'sh000001FFF;
            18: r = 36'sh000000FFF;
            19: r = 36'sh0000007FF;
            20: r = 36'sh0000003FF;
            21: r = 36'sh0000001FF;
            22: r = 36'sh0000000FF;
            23: r = 36'sh00000007F;
            24: r = 36'sh00000003F;
            25: r = 36'sh00000001F;
            26: r = 36'sh00000000F;
            27: r = 36'sh000000008;
            28: r = 36'sh000000004;
            29: r = 36'sh000000002;
            30: r = 36'sh000000001;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        logic signed [31:0] r;
        if (v > 68'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -68'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

@@ rtl/planar_pin_joint_jacobian_top.sv @@
`timescale 1ns / 1ps
// Planar pin joint evaluator.
// Channels: start/busy command input carrying in_item; result with strobe
// result_valid for one cycle; cfg_valid/cfg_ready/cfg_index/cfg_data writes
// the four anchor registers (the two-bit index selects one of the four).
// Path: rotator pipeline, product/error registers, saturated result register
// Throughput: one item per cycle; busy stays low, the pipeline of CORDIC
// cells, multipliers and saturation stages sets the latency.
// Reset clears the valid pipeline and the anchor registers to zero;
// items in flight are dropped.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Configuration may be written only while no item is in flight.
module planar_pin_joint_jacobian_top #(
    parameter int unsigned CORDIC_STAGES = 24
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  ppjj_pkg::in_item_t  in_item,
    output logic                result_valid,
    output ppjj_pkg::out_item_t result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data
);
    import ppjj_pkg::*;
    `include "assert_macros.svh"

    localparam int unsigned ROT_LAT = CORDIC_STAGES + 4;
    localparam int unsigned LAT = ROT_LAT + 2;

    logic signed [31:0] a1x_reg, a1y_reg, a2x_reg, a2y_reg;
    logic [LAT-1:0] vld_reg;
    logic signed [33:0] r1x, r1y, r2x, r2y;
    logic signed [31:0] w1_d [ROT_LAT];
    logic signed [31:0] w2_d [ROT_LAT];
    logic signed [31:0] p1x_d [ROT_LAT];
    logic signed [31:0] p1y_d [ROT_LAT];
    logic signed [31:0] p2x_d [ROT_LAT];
    logic signed [31:0] p2y_d [ROT_LAT];
    logic signed [65:0] m1x_reg, m1y_reg, m2x_reg, m2y_reg;
    logic signed [67:0] ex_reg, ey_reg;
    logic signed [33:0] r1x_reg, r1y_reg, r2x_reg, r2y_reg;
    out_item_t res_reg;
    logic accept;

    assign busy = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a1x_reg <= '0;
            a1y_reg <= '0;
            a2x_reg <= '0;
            a2y_reg <= '0;
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LAT-2:0], accept};
            if (cfg_valid && cfg_ready)
            begin
                case (reg_index_t'(cfg_index))
                    REG_FIRST_ANCHOR_X: a1x_reg <= cfg_data;
                    REG_FIRST_ANCHOR_Y: a1y_reg <= cfg_data;
                    REG_SECOND_ANCHOR_X: a2x_reg <= cfg_data;
                    REG_SECOND_ANCHOR_Y: a2y_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    ppjj_rotator #(.CORDIC_STAGES(CORDIC_STAGES)) u_rot1 (
        .clk(clk), .angle(in_item.first_angle), .anchor_x(a1x_reg),
        .anchor_y(a1y_reg), .rot_x(r1x), .rot_y(r1y)
    );
    ppjj_rotator #(.CORDIC_STAGES(CORDIC_STAGES)) u_rot2 (
        .clk(clk), .angle(in_item.second_angle), .anchor_x(a2x_reg),
        .anchor_y(a2y_reg), .rot_x(r2x), .rot_y(r2y)
    );

    always_ff @(posedge clk)
    begin
        w1_d[0] <= in_item.first_spin_rate;
        w2_d[0] <= in_item.second_spin_rate;
        p1x_d[0] <= in_item.first_pos_x;
        p1y_d[0] <= in_item.first_pos_y;
        p2x_d[0] <= in_item.second_pos_x;
        p2y_d[0] <= in_item.second_pos_y;
    end

    genvar g;
    generate
        for (g = 0; g < ROT_LAT - 1; g++)
        begin : g_dly
            always_ff @(posedge clk)
            begin
                w1_d[g+1] <= w1_d[g];
                w2_d[g+1] <= w2_d[g];
                p1x_d[g+1] <= p1x_d[g];
                p1y_d[g+1] <= p1y_d[g];
                p2x_d[g+1] <= p2x_d[g];
                p2y_d[g+1] <= p2y_d[g];
            end
        end
    endgenerate

    // rotator output aligns with delay index ROT_LAT-1
    always_ff @(posedge clk)
    begin
        m1x_reg <= -(w1_d[ROT_LAT-1] * r1x);
        m1y_reg <= -(w1_d[ROT_LAT-1] * r1y);
        m2x_reg <= w2_d[ROT_LAT-1] * r2x;
        m2y_reg <= w2_d[ROT_LAT-1] * r2y;
        ex_reg <= (68'(p1x_d[ROT_LAT-1]) + 68'(r1x)) - (68'(p2x_d[ROT_LAT-1]) + 68'(r2x));
        ey_reg <= (68'(p1y_d[ROT_LAT-1]) + 68'(r1y)) - (68'(p2y_d[ROT_LAT-1]) + 68'(r2y));
        r1x_reg <= r1x;
        r1y_reg <= r1y;
        r2x_reg <= r2x;
        r2y_reg <= r2y;

        res_reg.error_x <= sat32(ex_reg);
        res_reg.error_y <= sat32(ey_reg);
        res_reg.jac_first_row0 <= sat32(-68'(r1y_reg));
        res_reg.jac_first_row1 <= sat32(68'(r1x_reg));
        res_reg.jac_second_row0 <= sat32(68'(r2y_reg));
        res_reg.jac_second_row1 <= sat32(-68'(r2x_reg));
        res_reg.jdot_first_row0 <= sat32((68'(m1x_reg) + 68'sd32768) >>> 16);
        res_reg.jdot_first_row1 <= sat32((68'(m1y_reg) + 68'sd32768) >>> 16);
        res_reg.jdot_second_row0 <= sat32((68'(m2x_reg) + 68'sd32768) >>> 16);
        res_reg.jdot_second_row1 <= sat32((68'(m2y_reg) + 68'sd32768) >>> 16);
    end

    assign result = res_reg;
    assign result_valid = vld_reg[LAT-1];

    `ASSERT_NEXT(a_valid_shift, clk, rst_n, accept, vld_reg[0])
    `ASSERT_IMPL(a_never_busy, clk, rst_n, 1'b1, !busy && cfg_ready)
    `ASSERT_NEXT(a_out_follows, clk, rst_n, vld_reg[LAT-2], result_valid)
endmodule

@@ rtl/ppjj_cordic_cell.sv @@
`timescale 1ns / 1ps
module ppjj_cordic_cell #(
    parameter int unsigned STAGE = 0
) (
    input  logic               clk,
    input  ppjj_pkg::rot_lane_t lane_in,
    output ppjj_pkg::rot_lane_t lane_out
);
    import ppjj_pkg::*;

    rot_lane_t lane_next;
    rot_lane_t lane_reg;
    logic signed [CS_W-1:0] xs;
    logic signed [CS_W-1:0] ys;
    localparam logic signed [ANG_W-1:0] ATAN = atan_q30(STAGE);

    always_comb
    begin
        xs = lane_in.x >>> STAGE;
        ys = lane_in.y >>> STAGE;
        lane_next.flip = lane_in.flip;
        if (!lane_in.z[ANG_W-1])
        begin
            lane_next.x = lane_in.x - ys;
            lane_next.y = lane_in.y + xs;
            lane_next.z = lane_in.z - ATAN;
        end
        else
        begin
            lane_next.x = lane_in.x + ys;
            lane_next.y = lane_in.y - xs;
            lane_next.z = lane_in.z + ATAN;
        end
    end

    always_ff @(posedge clk)
    begin
        lane_reg <= lane_next;
    end

    assign lane_out = lane_reg;
endmodule

@@ rtl/ppjj_rotator.sv @@
`timescale 1ns / 1ps
module ppjj_rotator #(
    parameter int unsigned CORDIC_STAGES = 24
) (
    input  logic                clk,
    input  logic signed [31:0]  angle,
    input  logic signed [31:0]  anchor_x,
    input  logic signed [31:0]  anchor_y,
    output logic signed [33:0]  rot_x,
    output logic signed [33:0]  rot_y
);
    import ppjj_pkg::*;

    // angle reduction (1 reg), cells, unfold (1 reg), products (1 reg), sum (1 reg)
    rot_lane_t lane [CORDIC_STAGES+1];
    rot_lane_t lane0_next;
    rot_lane_t lane0_reg;
    logic signed [ANG_W-1:0] z_w;
    logic signed [ANG_W-1:0] z_r;
    logic signed [31:0] ax_d [CORDIC_STAGES+2];
    logic signed [31:0] ay_d [CORDIC_STAGES+2];
    logic signed [CS_W-1:0] c_reg;
    logic signed [CS_W-1:0] s_reg;
    logic signed [65:0] p_ca_reg, p_sb_reg, p_sa_reg, p_cb_reg;
    logic signed [67:0] sx;
    logic signed [67:0] sy;
    logic signed [33:0] rot_x_reg, rot_y_reg;

    always_comb
    begin
        z_w = ANG_W'(angle) <<< 2;
        z_r = z_w;
        if (z_w > Q30_PI)
            z_r = z_w - Q30_TWO_PI;
        else if (z_w < -Q30_PI)
            z_r = z_w + Q30_TWO_PI;
        lane0_next.x = Q30_GAIN;
        lane0_next.y = '0;
        lane0_next.flip = 1'b0;
        lane0_next.z = z_r;
        if (z_r > Q30_HALF_PI)
        begin
            lane0_next.z = z_r - Q30_PI;
            lane0_next.flip = 1'b1;
        end
        else if (z_r < -Q30_HALF_PI)
        begin
            lane0_next.z = z_r + Q30_PI;
            lane0_next.flip = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        lane0_reg <= lane0_next;
        ax_d[0] <= anchor_x;
        ay_d[0] <= anchor_y;
    end

    assign lane[0] = lane0_reg;

    genvar g;
    generate
        for (g = 0; g < CORDIC_STAGES; g++)
        begin : g_cell
            ppjj_cordic_cell #(.STAGE(g)) u_cell (
                .clk     (clk),
                .lane_in (lane[g]),
                .lane_out(lane[g+1])
            );
        end
        for (g = 0; g < CORDIC_STAGES + 1; g++)
        begin : g_anchor
            always_ff @(posedge clk)
            begin
                ax_d[g+1] <= ax_d[g];
                ay_d[g+1] <= ay_d[g];
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        c_reg <= lane[CORDIC_STAGES].flip ? -lane[CORDIC_STAGES].x : lane[CORDIC_STAGES].x;
        s_reg <= lane[CORDIC_STAGES].flip ? -lane[CORDIC_STAGES].y : lane[CORDIC_STAGES].y;
        p_ca_reg <= c_reg * ax_d[CORDIC_STAGES+1];
        p_sb_reg <= s_reg * ay_d[CORDIC_STAGES+1];
        p_sa_reg <= s_reg * ax_d[CORDIC_STAGES+1];
        p_cb_reg <= c_reg * ay_d[CORDIC_STAGES+1];
        rot_x_reg <= sx[63:30];
        rot_y_reg <= sy[63:30];
    end

    assign sx = 68'(p_ca_reg) - 68'(p_sb_reg) + 68'sd536870912;
    assign sy = 68'(p_sa_reg) + 68'(p_cb_reg) + 68'sd536870912;
    assign rot_x = rot_x_reg;
    assign rot_y = rot_y_reg;
endmodule

@@ test/planar_pin_joint_jacobian_top_tb.sv @@
`timescale 1ns / 1ps
module planar_pin_joint_jacobian_top_tb;
    import ppjj_pkg::*;

    localparam int STAGES = 24;
    localparam int LATENCY = STAGES + 6;
    localparam longint CYCLE_LIMIT = 600000;
    localparam longint PI_Q30 = 64'sd3373259426;
    localparam longint TWO_PI_Q30 = 64'sd6746518852;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint GAIN_Q30 = 64'sd652032874;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    in_item_t in_item = '0;
    logic result_valid;
    out_item_t result;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    int send_idle_pct = 0;
    longint cycle_count = 0;

    planar_pin_joint_jacobian_top #(.CORDIC_STAGES(STAGES)) i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
        .result_valid(result_valid), .result(result), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint arctan_q30(int i);
        longint tbl[32] = '{
            'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
            'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
            'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
            'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F,
            'h0000003F, 'h0000001F, 'h0000000F, 'h00000008, 'h00000004, 'h00000002,
            'h00000001, 'h00000000};
        return tbl[i];
    endfunction

    class joint_scoreboard;
        longint anchor[4];
        out_item_t pending[$];
        int mismatches;

        function new();
            anchor = '{0, 0, 0, 0};
            mismatches = 0;
        endfunction

        function void write_anchor(logic [1:0] idx, logic [31:0] val);
            anchor[idx] = longint'($signed(val));
        endfunction

        function void rotate_anchor(logic signed [31:0] ang, longint ax, longint ay,
                                    output longint rx, output longint ry);
            longint z, x, y, nx;
            bit flip;
            z = longint'(ang) * 4;
            x = GAIN_Q30;
            y = 0;
            flip = 0;
            while (z > PI_Q30) z -= TWO_PI_Q30;
            while (z < -PI_Q30) z += TWO_PI_Q30;
            if (z > HALF_PI_Q30) begin
                z -= PI_Q30;
                flip = 1;
            end
            else if (z < -HALF_PI_Q30) begin
                z += PI_Q30;
                flip = 1;
            end
            for (int i = 0; i < STAGES; i++) begin
                if (z >= 0) begin
                    nx = x - floor_shift(y, i);
                    y = y + floor_shift(x, i);
                    z -= arctan_q30(i);
                end
                else begin
                    nx = x + floor_shift(y, i);
                    y = y - floor_shift(x, i);
                    z += arctan_q30(i);
                end
                x = nx;
            end
            if (flip) begin
                x = -x;
                y = -y;
            end
            rx = floor_shift(x * ax - y * ay + (64'sd1 <<< 29), 30);
            ry = floor_shift(y * ax + x * ay + (64'sd1 <<< 29), 30);
        endfunction

        function void note_input(in_item_t it);
            longint r1x, r1y, r2x, r2y;
            out_item_t e;
            rotate_anchor(it.first_angle, anchor[0], anchor[1], r1x, r1y);
            rotate_anchor(it.second_angle, anchor[2], anchor[3], r2x, r2y);
            e.error_x = 32'(clamp32((longint'(it.first_pos_x) + r1x)
                                    - (longint'(it.second_pos_x) + r2x)));
            e.error_y = 32'(clamp32((longint'(it.first_pos_y) + r1y)
                                    - (longint'(it.second_pos_y) + r2y)));
            e.jac_first_row0 = 32'(clamp32(-r1y));
            e.jac_first_row1 = 32'(clamp32(r1x));
            e.jac_second_row0 = 32'(clamp32(r2y));
            e.jac_second_row1 = 32'(clamp32(-r2x));
            e.jdot_first_row0 = 32'(clamp32(floor_shift(-(longint'(it.first_spin_rate) * r1x)
                                                        + 32768, 16)));
            e.jdot_first_row1 = 32'(clamp32(floor_shift(-(longint'(it.first_spin_rate) * r1y)
                                                        + 32768, 16)));
            e.jdot_second_row0 = 32'(clamp32(floor_shift(longint'(it.second_spin_rate) * r2x
                                                         + 32768, 16)));
            e.jdot_second_row1 = 32'(clamp32(floor_shift(longint'(it.second_spin_rate) * r2y
                                                         + 32768, 16)));
            pending = {pending, e};
        endfunction

        function void compare(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v) begin
                $error("%s: expected %0d, actual %0d", name, $signed(exp_v), $signed(act_v));
                mismatches++;
            end
        endfunction

        function void check_result(out_item_t r);
            out_item_t e;
            if (pending.size() == 0) begin
                $error("result with no transfer pending");
                mismatches++;
                return;
            end
            e = pending.pop_front();
            compare("error_x", e.error_x, r.error_x);
            compare("error_y", e.error_y, r.error_y);
            compare("jac_first_row0", e.jac_first_row0, r.jac_first_row0);
            compare("jac_first_row1", e.jac_first_row1, r.jac_first_row1);
            compare("jac_second_row0", e.jac_second_row0, r.jac_second_row0);
            compare("jac_second_row1", e.jac_second_row1, r.jac_second_row1);
            compare("jdot_first_row0", e.jdot_first_row0, r.jdot_first_row0);
            compare("jdot_first_row1", e.jdot_first_row1, r.jdot_first_row1);
            compare("jdot_second_row0", e.jdot_second_row0, r.jdot_second_row0);
            compare("jdot_second_row1", e.jdot_second_row1, r.jdot_second_row1);
        endfunction
    endclass

    joint_scoreboard board = new();

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (rst_n && result_valid)
            board.check_result(result);
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 9))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return 32'h0;
            3: return 32'(signed'($urandom_range(0, 131072)) - 65536);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] rand_angle();
        if ($urandom_range(0, 3) == 0)
            return rand_word();
        return 32'(signed'($urandom_range(0, 1686629713)) - 843314856);
    endfunction

    task automatic write_cfg(reg_index_t idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        board.write_anchor(idx, val);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_item(in_item_t it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        in_item <= it;
        do @(posedge clk); while (busy);
        board.note_input(it);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic set_anchors(logic [31:0] a0, logic [31:0] a1,
                               logic [31:0] a2, logic [31:0] a3);
        write_cfg(REG_FIRST_ANCHOR_X, a0);
        write_cfg(REG_FIRST_ANCHOR_Y, a1);
        write_cfg(REG_SECOND_ANCHOR_X, a2);
        write_cfg(REG_SECOND_ANCHOR_Y, a3);
    endtask

    function automatic in_item_t rand_item();
        in_item_t it;
        it.first_angle = rand_angle();
        it.second_angle = rand_angle();
        it.first_spin_rate = rand_word();
        it.second_spin_rate = rand_word();
        it.first_pos_x = rand_word();
        it.first_pos_y = rand_word();
        it.second_pos_x = rand_word();
        it.second_pos_y = rand_word();
        return it;
    endfunction

    initial begin
        in_item_t it;
        int idle_tab[4] = '{0, 77, 0, 35};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_anchors(32'h00010000, 32'hFFFF0000, 32'h00028000, 32'h00008000);
        for (int k = 0; k < 16; k++) begin
            it = '0;
            case (k)
                0: ;
                1: it = '1;
                2: it = {8{32'h7FFFFFFF}};
                3: it = {8{32'h80000000}};
                4: it.first_angle = 32'sd843314857;
                5: it.first_angle = -32'sd843314857;
                6: it.second_angle = 32'sd421657428;
                7: it.second_angle = -32'sd421657429;
                8: it.first_angle = 32'h7FFFFFFF;
                9: it.second_angle = 32'h80000000;
                default: it = rand_item();
            endcase
            send_item(it);
        end
        drain();
        set_anchors(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000);
        for (int k = 0; k < 8; k++) begin
            it = rand_item();
            if (k < 2) begin
                it.first_spin_rate = 32'h7FFFFFFF;
                it.second_spin_rate = 32'h80000000;
            end
            send_item(it);
        end
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            send_idle_pct = idle_tab[ph % 4];
            if (ph == 4)
                set_anchors(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000);
            else
                set_anchors(rand_word(), rand_word(), rand_word(), rand_word());
            for (int k = 0; k < 135; k++)
                send_item(rand_item());
            drain();
        end

        if (board.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

@@ planar_pin_joint_jacobian_top.f @@
+incdir+rtl
rtl/ppjj_pkg.sv
rtl/ppjj_cordic_cell.sv
rtl/ppjj_rotator.sv
rtl/planar_pin_joint_jacobian_top.sv
test/planar_pin_joint_jacobian_top_tb.sv
